[src/ptt_pkg.sv]
// Package for the periodic task timer table: operation codes, result kinds,
// field widths and default sizing. Used by periodic_task_timer_table.
`default_nettype none

package ptt_pkg;

    // Field widths of the request and result items.
    localparam int FUNC_W   = 2;
    localparam int PERIOD_W = 32;
    localparam int SLOT_W   = 3;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 32;

    // Packed stream widths (tdata rounded up to whole bytes).
    localparam int S_DATA_W = ((PERIOD_W + SLOT_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((SLOT_W + COUNT_W + 7) / 8) * 8;

    localparam int NUM_SLOTS_DEF = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_REGISTER   = 2'd1,
        FUNC_UNREGISTER = 2'd2,
        FUNC_NONE       = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED        = 3'd0,
        KIND_TICK_DONE    = 3'd1,
        KIND_REGISTERED   = 3'd2,
        KIND_FULL         = 3'd3,
        KIND_UNREGISTERED = 3'd4
    } kind_t;

endpackage

`default_nettype wire

[src/periodic_task_timer_table.sv]
// Top level of the periodic task timer table: slot tables, scan sequencer
// and result register. Depends on ptt_pkg.
`default_nettype none

// Usage
// Requests arrive on the s_axis group: s_tuser carries the operation (tick,
// register task, unregister task), s_tdata the period and the slot. Results
// leave on the m_axis group: m_tuser carries the result kind, m_tdata the
// slot index and the tick counter, m_tlast marks the final result of a
// request.
// A tick scans all NUM_SLOTS slots through one shared subtract-and-compare
// unit, one slot per cycle while no fire result stalls, reading the period
// and last-fire memories into registers one slot ahead of the compare. Every
// fire result that finds the result register still occupied holds the scan
// for as long as the receiver stalls.
// A register request walks the in-use bits from slot 0 until it finds a free
// slot. Operation code 3 is dropped with no result.
// s_tready is high only while the sequencer is idle; the result register
// lets a new request be accepted while the last result still waits.
// Reset clears the in-use bits, the tick counter and the sequencer; the
// period and last-fire memories are not cleared, since a slot's entries are
// always written when the slot is marked in use.

module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [S_DATA_W-1:0] s_tdata,   // period [31:0], slot [34:32], zero fill
    input  wire  [FUNC_W-1:0]   s_tuser,   // func [1:0]
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // slot_index [2:0], tick_count [34:3], zero fill
    output logic [KIND_W-1:0]   m_tuser,   // result_kind [2:0]
    output logic                m_tlast    // last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_RESP
    } state_t;

    // Slot tables. The in-use bits live in flip-flops so reset clears them.
    logic [PERIOD_W-1:0] period_mem [NUM_SLOTS];
    logic [COUNT_W-1:0]  last_mem   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] in_use_reg;

    state_t              state_reg;
    logic [COUNT_W-1:0]  tick_cnt_reg;
    logic [CNT_W-1:0]    rd_cnt_reg;
    logic                chk_valid_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic [PERIOD_W-1:0] rd_period_reg;
    logic [COUNT_W-1:0]  rd_last_reg;
    logic [PERIOD_W-1:0] req_period_reg;

    // Staged result waiting for the result register.
    kind_t               res_kind_reg;
    logic [SLOT_W-1:0]   res_slot_reg;

    // Result register.
    logic                m_valid_reg;
    kind_t               m_kind_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic                m_last_reg;

    // Request fields.
    func_t               req_func;
    logic [PERIOD_W-1:0] req_period;
    logic [SLOT_W-1:0]   req_slot;
    logic [IDX_W+SLOT_W-1:0] req_slot_ext;
    logic [IDX_W-1:0]    req_slot_idx;
    logic                req_slot_ok;
    logic                s_accept;

    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W+SLOT_W-1:0] chk_idx_ext;
    logic [IDX_W+SLOT_W-1:0] rd_idx_ext;
    logic [COUNT_W-1:0]  elapsed;
    logic                fire;
    logic                out_free;
    logic                out_load;
    logic                stall;
    logic                scan_advance;
    logic                fire_write;
    logic                alloc_write;

    assign req_func   = func_t'(s_tuser);
    assign req_period = s_tdata[PERIOD_W-1:0];
    assign req_slot   = s_tdata[PERIOD_W+SLOT_W-1:PERIOD_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;

    // Slot numbers move between the 3-bit fields and the internal index
    // width by zero extension followed by truncation.
    assign req_slot_ext = {{IDX_W{1'b0}}, req_slot};
    assign req_slot_idx = req_slot_ext[IDX_W-1:0];
    assign req_slot_ok  = (32'(req_slot) < 32'(NUM_SLOTS));

    assign rd_idx      = rd_cnt_reg[IDX_W-1:0];
    assign chk_idx_ext = {{SLOT_W{1'b0}}, chk_idx_reg};
    assign rd_idx_ext  = {{SLOT_W{1'b0}}, rd_idx};

    // The shared unit: modular elapsed ticks compared against the period.
    assign elapsed = tick_cnt_reg - rd_last_reg;
    assign fire    = in_use_reg[chk_idx_reg] && (elapsed >= rd_period_reg);

    assign out_free     = !m_valid_reg || m_tready;
    assign stall        = chk_valid_reg && fire && !out_free;
    assign scan_advance = (state_reg == S_SCAN) && !stall && (rd_cnt_reg < NUM_CNT);
    assign fire_write   = (state_reg == S_SCAN) && chk_valid_reg && fire && !stall;
    assign alloc_write  = (state_reg == S_ALLOC) && !in_use_reg[rd_idx];

    // The result register takes a new result in this cycle.
    assign out_load     = fire_write || ((state_reg == S_RESP) && out_free);

    // Memory ports: one registered read for the scan, one write each.
    always_ff @(posedge clk)
    begin
        if (scan_advance)
        begin
            rd_period_reg <= period_mem[rd_idx];
            rd_last_reg   <= last_mem[rd_idx];
        end
        if (alloc_write)
        begin
            period_mem[rd_idx] <= req_period_reg;
            last_mem[rd_idx]   <= tick_cnt_reg;
        end
        else if (fire_write)
        begin
            last_mem[chk_idx_reg] <= tick_cnt_reg;
        end
    end

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            in_use_reg     <= '0;
            tick_cnt_reg   <= '0;
            rd_cnt_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            req_period_reg <= '0;
            res_kind_reg   <= KIND_TICK_DONE;
            res_slot_reg   <= '0;
            m_valid_reg    <= 1'b0;
            m_kind_reg     <= KIND_TICK_DONE;
            m_slot_reg     <= '0;
            m_count_reg    <= '0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !out_load)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        rd_cnt_reg    <= '0;
                        chk_valid_reg <= 1'b0;
                        unique case (req_func)
                            FUNC_TICK:
                            begin
                                tick_cnt_reg <= tick_cnt_reg + COUNT_W'(1);
                                state_reg    <= S_SCAN;
                            end
                            FUNC_REGISTER:
                            begin
                                req_period_reg <= req_period;
                                state_reg      <= S_ALLOC;
                            end
                            FUNC_UNREGISTER:
                            begin
                                if (req_slot_ok)
                                begin
                                    in_use_reg[req_slot_idx] <= 1'b0;
                                end
                                res_kind_reg <= KIND_UNREGISTERED;
                                res_slot_reg <= req_slot;
                                state_reg    <= S_RESP;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_ALLOC:
                begin
                    // Walk the in-use bits from the lowest slot upward.
                    if (!in_use_reg[rd_idx])
                    begin
                        in_use_reg[rd_idx] <= 1'b1;
                        res_kind_reg       <= KIND_REGISTERED;
                        res_slot_reg       <= rd_idx_ext[SLOT_W-1:0];
                        state_reg          <= S_RESP;
                    end
                    else if (rd_cnt_reg == LAST_CNT)
                    begin
                        res_kind_reg <= KIND_FULL;
                        res_slot_reg <= '0;
                        state_reg    <= S_RESP;
                    end
                    else
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    end
                end

                S_SCAN:
                begin
                    // Reads run one slot ahead of the compare; a fire that
                    // cannot be delivered holds both.
                    if (!stall)
                    begin
                        if (chk_valid_reg && fire)
                        begin
                            m_valid_reg <= 1'b1;
                            m_kind_reg  <= KIND_FIRED;
                            m_slot_reg  <= chk_idx_ext[SLOT_W-1:0];
                            m_count_reg <= tick_cnt_reg;
                            m_last_reg  <= 1'b0;
                        end
                        if (rd_cnt_reg < NUM_CNT)
                        begin
                            chk_valid_reg <= 1'b1;
                            chk_idx_reg   <= rd_idx;
                            rd_cnt_reg    <= rd_cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            chk_valid_reg <= 1'b0;
                            if (!chk_valid_reg)
                            begin
                                res_kind_reg <= KIND_TICK_DONE;
                                res_slot_reg <= '0;
                                state_reg    <= S_RESP;
                            end
                        end
                    end
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= res_kind_reg;
                        m_slot_reg  <= res_slot_reg;
                        m_count_reg <= tick_cnt_reg;
                        m_last_reg  <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - SLOT_W - COUNT_W){1'b0}}, m_count_reg, m_slot_reg};

endmodule

`default_nettype wire

[dv/periodic_task_timer_table_tb.sv]
// Self-checking testbench for periodic_task_timer_table: directed and random requests
// with random stalls on both stream groups, checked against an internal slot-table model.
// Depends on ptt_pkg and the periodic_task_timer_table RTL.
`timescale 1ns / 100ps

module periodic_task_timer_table_tb;

    import ptt_pkg::*;

    localparam int NUM_SLOTS = NUM_SLOTS_DEF;

    // The drain wait at the end covers several full scans of the table.
    localparam int DRAIN_CYCLES = 60;

    // The receiver holds off for this long once.
    // The request side then backs up and s_tready drops.
    localparam int HOLD_OFF_CYCLES = 400;

    // The slowest correct gap between two handshakes on either group is the
    // hold-off above plus one full scan. The limit allows that many times over.
    localparam int STUCK_LIMIT = 4000;

    localparam int RANDOM_REQUESTS = 160;

    // One result as it appears on the master-side group.
    typedef struct {
        kind_t                kind;
        logic [SLOT_W-1:0]    slot_index;
        logic [COUNT_W-1:0]   tick_count;
        logic                 is_last;
    } timer_result_t;

    // Scoreboard: it keeps its own copy of the slot table and the tick counter.
    // It turns every accepted request into the results that the block should
    // send, and it compares each result that leaves the block with the oldest
    // one still waiting.
    class timer_table_scoreboard;
        bit                   in_use [NUM_SLOTS];
        logic [PERIOD_W-1:0]  period_of [NUM_SLOTS];
        logic [COUNT_W-1:0]   last_fire [NUM_SLOTS];
        logic [COUNT_W-1:0]   ticks;
        timer_result_t        pending_results [$];
        int                   errors;

        function new();
            foreach (in_use[i])
            begin
                in_use[i] = 1'b0;
            end
            ticks  = '0;
            errors = 0;
        endfunction

        function void push_result(kind_t kind, int idx, bit is_last);
            timer_result_t r;
            r.kind       = kind;
            r.slot_index = SLOT_W'(idx);
            r.tick_count = ticks;
            r.is_last    = is_last;
            pending_results.push_back(r);
        endfunction

        function void note_request(func_t func, logic [PERIOD_W-1:0] period,
                                   logic [SLOT_W-1:0] slot);
            logic [COUNT_W-1:0] elapsed;
            bit                 placed;
            placed = 1'b0;
            case (func)
                FUNC_TICK:
                begin
                    ticks = ticks + 1'b1;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        // Elapsed ticks are taken modulo 2^32, so a zero
                        // period fires on every tick.
                        elapsed = ticks - last_fire[i];
                        if (in_use[i] && elapsed >= period_of[i])
                        begin
                            last_fire[i] = ticks;
                            push_result(KIND_FIRED, i, 1'b0);
                        end
                    end
                    push_result(KIND_TICK_DONE, 0, 1'b1);
                end
                FUNC_REGISTER:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!placed && !in_use[i])
                        begin
                            in_use[i]    = 1'b1;
                            period_of[i] = period;
                            last_fire[i] = ticks;
                            push_result(KIND_REGISTERED, i, 1'b1);
                            placed = 1'b1;
                        end
                    end
                    if (!placed)
                    begin
                        push_result(KIND_FULL, 0, 1'b1);
                    end
                end
                FUNC_UNREGISTER:
                begin
                    // A free or out-of-range slot still gets its result.
                    if (slot < NUM_SLOTS)
                    begin
                        in_use[slot] = 1'b0;
                    end
                    push_result(KIND_UNREGISTERED, slot, 1'b1);
                end
                default:
                begin
                    // The unused operation code is dropped without a result.
                end
            endcase
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot_index,
                                   logic [COUNT_W-1:0] tick_count, logic is_last);
            timer_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d count %0d last %0d",
                       kind, slot_index, tick_count, is_last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind)
            begin
                $error("result_kind mismatch: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (slot_index !== want.slot_index)
            begin
                $error("slot_index mismatch: expected %0d, actual %0d",
                       want.slot_index, slot_index);
                errors++;
            end
            if (tick_count !== want.tick_count)
            begin
                $error("tick_count mismatch: expected %0d, actual %0d",
                       want.tick_count, tick_count);
                errors++;
            end
            if (is_last !== want.is_last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.is_last, is_last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;     // period [31:0], slot [34:32], zero fill
    logic [FUNC_W-1:0]   s_tuser  = '0;     // func [1:0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // slot_index [2:0], tick_count [34:3], zero fill
    logic [KIND_W-1:0]   m_tuser;           // result_kind [2:0]
    logic                m_tlast;

    timer_table_scoreboard board;

    // Steady is set during a stretch in which neither side idles.
    bit steady        = 1'b0;
    bit hold_off_req  = 1'b0;
    int stuck_cycles  = 0;

    periodic_task_timer_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Offer one request and wait until it is accepted. A random gap can come
    // first, with s_tvalid low. When there is no gap, the request follows the
    // previous one back to back, and s_tvalid stays high.
    task automatic send_request(func_t func, logic [PERIOD_W-1:0] period,
                                logic [SLOT_W-1:0] slot);
        logic [S_DATA_W-1:0] word;
        word                          = '0;
        word[PERIOD_W-1:0]            = period;
        word[PERIOD_W +: SLOT_W]      = slot;
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= word;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        board.note_request(func, period, slot);
    endtask

    // Results are sampled at the rising edge, before the block updates its
    // outputs for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tuser, m_tdata[SLOT_W-1:0],
                               m_tdata[SLOT_W +: COUNT_W], m_tlast);
        end
    end

    // Receiver: it stalls in about a quarter of the cycles, except during the
    // steady stretch. Once during the run it holds off for a long stretch, and
    // this process counts those cycles itself.
    initial
    begin : receiver
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= steady || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Watchdog: it counts the cycles in which neither group completes a handshake.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[periodic_task_timer_table] ERROR");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int                  pick;
        logic [PERIOD_W-1:0] period;
        logic [SLOT_W-1:0]   slot;

        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. It starts with a tick on an empty table and with an
        // unregister of a free slot. A dropped operation code comes next.
        send_request(FUNC_TICK, '0, '0);
        send_request(FUNC_UNREGISTER, '0, 3'd5);
        send_request(FUNC_NONE, '1, '1);

        // The table is filled with the extremes of the period: zero fires on
        // every tick, and all ones never fires in a run of this length. The
        // counter cannot wrap within the run, since it starts from zero after
        // the only reset. The ninth register request finds the table full.
        send_request(FUNC_REGISTER, 32'h0000_0000, '0);
        send_request(FUNC_REGISTER, 32'hFFFF_FFFF, '1);
        send_request(FUNC_REGISTER, 32'd1, '0);
        send_request(FUNC_REGISTER, 32'd2, '0);
        send_request(FUNC_REGISTER, 32'hA5A5_5A5A, '0);
        send_request(FUNC_REGISTER, 32'd3, '0);
        send_request(FUNC_REGISTER, 32'h5A5A_A5A5, '0);
        send_request(FUNC_REGISTER, 32'd1, '0);
        send_request(FUNC_REGISTER, 32'd7, '0);

        // Several ticks with a full table, so that up to nine results follow one request.
        repeat (3) send_request(FUNC_TICK, '1, '1);

        // A freed slot is reused by the next register request, since the lowest free slot is taken.
        send_request(FUNC_UNREGISTER, '0, 3'd3);
        send_request(FUNC_REGISTER, 32'd0, '0);
        send_request(FUNC_TICK, '0, '0);

        // The top slot is freed twice. The second unregister finds it free already.
        send_request(FUNC_UNREGISTER, '1, 3'd7);
        send_request(FUNC_UNREGISTER, '0, 3'd7);
        send_request(FUNC_NONE, $urandom(), 3'($urandom()));
        send_request(FUNC_TICK, '0, '0);

        // Random part. Most register requests use short periods, so that the
        // slots fire often. Fields that an operation does not use carry
        // random values.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 50)
            begin
                hold_off_req = 1'b1;
            end
            steady = (n >= 90 && n < 130);
            pick   = $urandom_range(0, 99);
            slot   = 3'($urandom());
            if ($urandom_range(0, 4) == 0)
            begin
                period = $urandom();
            end
            else
            begin
                period = $urandom_range(0, 10);
            end
            if (pick < 45)
            begin
                send_request(FUNC_TICK, period, slot);
            end
            else if (pick < 70)
            begin
                send_request(FUNC_REGISTER, period, slot);
            end
            else if (pick < 95)
            begin
                send_request(FUNC_UNREGISTER, period, slot);
            end
            else
            begin
                send_request(FUNC_NONE, period, slot);
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
        begin
            $display("[periodic_task_timer_table] OK");
        end
        else
        begin
            $display("[periodic_task_timer_table] ERROR");
        end
        $finish;
    end

endmodule
